// ===== hw/rtl/twc_pkg.sv =====
// Shared types and constants for the text-mode console writer.
package twc_pkg;

	localparam int unsigned SCREEN_WIDTH_DFLT  = 80;
	localparam int unsigned SCREEN_HEIGHT_DFLT = 25;

	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned COLOR_W  = 8;
	localparam int unsigned ROW_IN_W = 5;
	localparam int unsigned COL_IN_W = 7;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned CELL_W   = CHAR_W + COLOR_W;

	localparam int unsigned TAB_STOP = 4;
	localparam int unsigned TAB_BITS = $clog2(TAB_STOP);

	localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0]  CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
	localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;
	localparam logic [CELL_W-1:0]  CELL_RESET   = 16'h0F20;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUT     = 2'd0,
		OP_SET_POS = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_TAB,
		ST_FILL,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [CHAR_W-1:0]   char_code;
		logic [COLOR_W-1:0]  color;
		logic [ROW_IN_W-1:0] target_row;
		logic [COL_IN_W-1:0] target_column;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_word;
	} rsp_t;

endpackage

// ===== hw/rtl/twc_if.sv =====
// Valid/ready channel interfaces for command and response words.
interface twc_cmd_if;
	import twc_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface twc_rsp_if;
	import twc_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/twc_screen_ram.sv =====
// Screen cell memory: one write port, one registered read port.
module twc_screen_ram #(
	parameter int unsigned DEPTH = twc_pkg::SCREEN_WIDTH_DFLT * twc_pkg::SCREEN_HEIGHT_DFLT,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [twc_pkg::CELL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [twc_pkg::CELL_W-1:0] rdata
);
	import twc_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/text_mode_console_writer_core.sv =====
// Top level of the text-mode console writer: cursor control and screen sequencing.
//
//   channel  dir  handshake              word
//   cmd      in   cmd.valid/cmd.ready    opcode, char_code, color, target_row, target_column
//   rsp      out  rsp.valid/rsp.ready    cursor_position, cell_word
//   cfg      in   cfg_we                 cfg_wdata -> default_color
//
// Printable, newline, return, backspace, set position and unused opcode run through
// EXEC and EMIT; a printable at the wrap position runs a newline first.
// Read cell: EXEC, READ (registered memory read) and EMIT. Tab: EXEC, then TAB blanks
// cells one by one, then EMIT; a newline runs first at the wrap position.
// A newline on the last row recycles the top row: the row base pointer advances
// and the new bottom row is blanked at one cell per cycle.
// After reset the memory is swept to blank before the first command word is taken;
// cfg writes are taken at any time.
// A new command is taken while a response waits in the output register.
module text_mode_console_writer_core #(
	parameter int unsigned SCREEN_WIDTH  = twc_pkg::SCREEN_WIDTH_DFLT,
	parameter int unsigned SCREEN_HEIGHT = twc_pkg::SCREEN_HEIGHT_DFLT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	twc_cmd_if.sink                     cmd,
	twc_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [twc_pkg::COLOR_W-1:0] cfg_wdata
);
	import twc_pkg::*;

	localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned RW    = $clog2(SCREEN_HEIGHT);
	localparam int unsigned CW    = $clog2(SCREEN_WIDTH + 1);
	localparam int unsigned PW    = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	state_t            after_fill_q, after_fill_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [RW-1:0]     top_q, top_d;
	logic [COLOR_W-1:0] dflt_color_q;
	cmd_t              cmd_s1;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic              out_valid_q;
	rsp_t              out_data_q;

	logic              out_free;
	logic              cmd_fire;
	logic              emit;
	logic              nl_req;
	state_t            nl_cont;
	logic [RW-1:0]     clamp_row;
	logic [CW-1:0]     clamp_col;
	logic [CW-1:0]     read_col;
	logic [CW-1:0]     col_inc;
	logic [PW-1:0]     pos_full;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Logical row r lives in physical row (r + top) mod height.
	function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c,
			logic [RW-1:0] top);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, top};
		if (s >= (RW+1)'(SCREEN_HEIGHT)) begin
			s = s - (RW+1)'(SCREEN_HEIGHT);
		end
		return AW'(s) * AW'(SCREEN_WIDTH) + AW'(c);
	endfunction

	twc_screen_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) || (state_q == ST_EMIT && out_free);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	assign col_inc  = col_q + 1'b1;
	assign pos_full = PW'(row_q) * PW'(SCREEN_WIDTH) + PW'(col_q);

	always_comb begin
		if (int'(cmd_s1.target_row) > SCREEN_HEIGHT - 1) begin
			clamp_row = RW'(SCREEN_HEIGHT - 1);
		end else begin
			clamp_row = RW'(cmd_s1.target_row);
		end
		if (int'(cmd_s1.target_column) > SCREEN_WIDTH) begin
			clamp_col = CW'(SCREEN_WIDTH);
		end else begin
			clamp_col = CW'(cmd_s1.target_column);
		end
		if (int'(cmd_s1.target_column) > SCREEN_WIDTH - 1) begin
			read_col = CW'(SCREEN_WIDTH - 1);
		end else begin
			read_col = CW'(cmd_s1.target_column);
		end
	end

	always_comb begin
		state_d      = state_q;
		after_fill_d = after_fill_q;
		cnt_d        = cnt_q;
		row_d        = row_q;
		col_d        = col_q;
		top_d        = top_q;
		cell_d       = cell_q;
		emit         = 1'b0;
		nl_req       = 1'b0;
		nl_cont      = ST_EMIT;
		ram_we       = 1'b0;
		ram_waddr    = cell_addr(row_q, col_q, top_q);
		ram_wdata    = {cmd_s1.color, BLANK_CHAR};
		ram_re       = 1'b0;
		ram_raddr    = cell_addr(clamp_row, read_col, top_q);

		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = CELL_RESET;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cell_d  = '0;
				state_d = ST_EMIT;
				unique case (opcode_t'(cmd_s1.opcode))
					OP_PUT: begin
						case (cmd_s1.char_code)
							CH_NEWLINE: begin
								nl_req = 1'b1;
							end
							CH_RETURN: begin
								col_d = '0;
							end
							CH_BACKSPACE: begin
								if (col_q == '0) begin
									if (row_q != '0) begin
										row_d     = row_q - 1'b1;
										col_d     = CW'(SCREEN_WIDTH - 1);
										ram_we    = 1'b1;
										ram_waddr = cell_addr(row_q - 1'b1,
											CW'(SCREEN_WIDTH - 1), top_q);
									end
								end else begin
									col_d     = col_q - 1'b1;
									ram_we    = 1'b1;
									ram_waddr = cell_addr(row_q, col_q - 1'b1, top_q);
								end
							end
							CH_TAB: begin
								// at the wrap position: newline, then run the tab again
								if (col_q >= CW'(SCREEN_WIDTH)) begin
									nl_req  = 1'b1;
									nl_cont = ST_EXEC;
								end else begin
									state_d = ST_TAB;
								end
							end
							default: begin
								if (col_q >= CW'(SCREEN_WIDTH)) begin
									nl_req  = 1'b1;
									nl_cont = ST_EXEC;
								end else begin
									ram_we    = 1'b1;
									ram_wdata = {cmd_s1.color, cmd_s1.char_code};
									col_d     = col_inc;
								end
							end
						endcase
					end
					OP_SET_POS: begin
						row_d = clamp_row;
						col_d = clamp_col;
					end
					OP_READ: begin
						ram_re  = 1'b1;
						state_d = ST_READ;
					end
					default: begin
					end
				endcase

				if (nl_req) begin
					col_d = '0;
					if (row_q < RW'(SCREEN_HEIGHT - 1)) begin
						row_d   = row_q + 1'b1;
						state_d = nl_cont;
					end else begin
						// scroll: the old top row becomes the new bottom row
						top_d        = (top_q == RW'(SCREEN_HEIGHT - 1)) ? '0 : top_q + 1'b1;
						cnt_d        = '0;
						after_fill_d = nl_cont;
						state_d      = ST_FILL;
					end
				end
			end
			ST_TAB: begin
				ram_we = 1'b1;
				col_d  = col_inc;
				if (col_inc[TAB_BITS-1:0] == '0 || col_inc == CW'(SCREEN_WIDTH)) begin
					state_d = ST_EMIT;
				end
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(RW'(SCREEN_HEIGHT - 1), cnt_q[CW-1:0], top_q);
				ram_wdata = {dflt_color_q, BLANK_CHAR};
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q[CW-1:0] == CW'(SCREEN_WIDTH - 1)) begin
					state_d = after_fill_q;
				end
			end
			ST_READ: begin
				cell_d  = ram_rdata;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = cmd_fire ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			after_fill_q <= ST_EMIT;
			cnt_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			top_q        <= '0;
			dflt_color_q <= COLOR_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			after_fill_q <= after_fill_d;
			cnt_q        <= cnt_d;
			row_q        <= row_d;
			col_q        <= col_d;
			top_q        <= top_d;
			if (cfg_we) begin
				dflt_color_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
		if (cmd_fire) begin
			cmd_s1 <= cmd.data;
		end
		if (emit) begin
			out_data_q.cursor_position <= POS_W'(pos_full);
			out_data_q.cell_word       <= cell_q;
		end
	end

endmodule
